// ===== sv/bvg_pkg.sv =====
// Shared types and constants of the battery voltage gauge.
`default_nettype none

package bvg_pkg;

   // Sample and accumulator widths
   localparam int ADC_BITS  = 12;
   localparam int SUM_BITS  = ADC_BITS + 8;
   localparam int CNT_W     = 8;

   // Register and field widths
   localparam int MV_W      = 14;
   localparam int MVQ_W     = 24;
   localparam int ALPHA_W   = 16;
   localparam int FRAC_W    = 8;
   localparam int SMOOTH_W  = MV_W + FRAC_W;
   localparam int AVG_W     = 12;
   localparam int PCT_W     = 7;

   // Shared divider: percentage quotient never reaches 2^PCT_QB
   localparam int PCT_QB    = 6;
   localparam int X_W       = 22;
   localparam int DQ_W      = (SUM_BITS > X_W) ? SUM_BITS : X_W;
   localparam int REM_W     = 17;
   localparam int STEP_W    = $clog2(DQ_W + 1);

   // Shared multiplier
   localparam int MUL_A_W   = DQ_W;
   localparam int MUL_B_W   = MVQ_W;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int V_W       = PROD_W - FRAC_W;
   localparam int ACC_W     = 40;
   localparam int FSUM_W    = ACC_W + 1;
   localparam int ONE_Q16   = 65536;
   localparam int HALF_Q16  = 32768;

   // Piecewise-linear LiPo curve, voltages in Q8 mV
   localparam int SEG_N     = 5;
   localparam int SEG_W     = 3;
   localparam int D_W       = 16;
   localparam logic [SMOOTH_W-1:0] PCT_LO_Q8 = SMOOTH_W'(3300 * 256);
   localparam logic [SMOOTH_W-1:0] PCT_HI_Q8 = SMOOTH_W'(4200 * 256);
   localparam logic [PCT_W-1:0]    PCT_FULL  = PCT_W'(100);
   localparam logic [PCT_W-1:0]    PCT_EMPTY = '0;

   localparam logic [SMOOTH_W-1:0] SEG_BP_Q8 [SEG_N] = '{
      SMOOTH_W'(3300 * 256), SMOOTH_W'(3500 * 256), SMOOTH_W'(3700 * 256),
      SMOOTH_W'(3900 * 256), SMOOTH_W'(4050 * 256)};
   // half divisor (span in Q8) and full divisor (twice the span)
   localparam logic [X_W-1:0]   SEG_HALF [SEG_N] = '{
      X_W'(200 * 256), X_W'(200 * 256), X_W'(200 * 256),
      X_W'(150 * 256), X_W'(150 * 256)};
   localparam logic [REM_W-1:0] SEG_DIV  [SEG_N] = '{
      REM_W'(400 * 256), REM_W'(400 * 256), REM_W'(400 * 256),
      REM_W'(300 * 256), REM_W'(300 * 256)};
   localparam logic [PCT_W-1:0] SEG_BASE [SEG_N] = '{
      PCT_W'(0), PCT_W'(10), PCT_W'(40), PCT_W'(75), PCT_W'(92)};
   localparam logic [PCT_W-1:0] SEG_RISE2 [SEG_N] = '{
      PCT_W'(20), PCT_W'(60), PCT_W'(70), PCT_W'(34), PCT_W'(16)};

   // Register map
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MV_PER_COUNT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VALID_MIN      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VALID_MAX      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CONN_MIN       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CONN_MAX       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGE_ACT_LOW = 3'd7;
   localparam int CSR_DATA_W = MVQ_W;

   // Register reset values
   localparam logic [CNT_W-1:0]   RST_SAMPLE_COUNT = CNT_W'(1);
   localparam logic [MVQ_W-1:0]   RST_MV_PER_COUNT = MVQ_W'(170394);
   localparam logic [ALPHA_W-1:0] RST_ALPHA        = ALPHA_W'(6554);
   localparam logic [MV_W-1:0]    RST_VALID_MIN    = MV_W'(2500);
   localparam logic [MV_W-1:0]    RST_VALID_MAX    = MV_W'(5000);
   localparam logic [MV_W-1:0]    RST_CONN_MIN     = MV_W'(3000);
   localparam logic [MV_W-1:0]    RST_CONN_MAX     = MV_W'(4300);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV,
      S_MULV,
      S_CHECK,
      S_MULS,
      S_MULI,
      S_FILT,
      S_PSEL,
      S_PMUL,
      S_PLOAD,
      S_PDIV,
      S_PSUM,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== sv/battery_voltage_gauge.sv =====
// Top level of the battery voltage gauge: burst averaging, scaling, filter, percentage.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   adc_sample, charge_pin
//   rsp_      out        rsp_valid/rsp_stall   raw_average .. charging
//   csr_      in         csr_valid/csr_ready   csr_index, csr_data
//
// A sample that does not close a burst is simply added to the burst sum. A sample that closes a burst
// holds req_stall through SUM_BITS (20) shared divider steps for the average,
// one shared multiplier pass each for scaling, the two filter products and the curve, then
// PCT_QB (6) divider steps; the first reading skips the filter and a voltage off
// the curve skips the percentage. Hold the input stalled in S_DONE until the
// output register is free; reset is synchronous and restores registers and burst state.
`default_nettype none

module battery_voltage_gauge
   import bvg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // samples
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [ADC_BITS-1:0]   req_adc_sample,
   input  wire logic                  req_charge_pin,
   // results
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [AVG_W-1:0]           rsp_raw_average,
   output logic [MV_W-1:0]            rsp_instant_mv,
   output logic [MV_W-1:0]            rsp_smoothed_mv_out,
   output logic [PCT_W-1:0]           rsp_charge_percent,
   output logic                       rsp_reading_replaced,
   output logic                       rsp_battery_connected,
   output logic                       rsp_charging,
   // configuration
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // ---------------------------------------------------------------- registers
   state_type state_ff, state_in;

   logic [CNT_W-1:0]    sample_count_ff;
   logic [MVQ_W-1:0]    mv_per_count_ff;
   logic [ALPHA_W-1:0]  alpha_ff;
   logic [MV_W-1:0]     valid_min_ff, valid_max_ff, conn_min_ff, conn_max_ff;
   logic                charge_act_low_ff;

   logic [SUM_BITS-1:0] sum_ff;
   logic [CNT_W-1:0]    taken_ff;
   logic                pin_ff;
   logic                seeded_ff;
   logic [SMOOTH_W-1:0] smooth_ff;

   // shared divider
   logic [REM_W-1:0]    rem_ff;
   logic [DQ_W-1:0]     dq_ff;
   logic [REM_W-1:0]    div_ff;
   logic [STEP_W-1:0]   cnt_ff;

   // shared multiplier
   logic [PROD_W-1:0]   prod_ff;
   logic [ACC_W-1:0]    acc_ff;

   logic [AVG_W-1:0]    avg_ff;
   logic [SMOOTH_W-1:0] inst_ff;
   logic                repl_ff;
   logic [SEG_W-1:0]    seg_ff;
   logic [D_W-1:0]      d_ff;
   logic [PCT_W-1:0]    pct_ff;

   logic                rsp_valid_ff;
   logic [AVG_W-1:0]    rsp_avg_ff;
   logic [MV_W-1:0]     rsp_inst_ff, rsp_smooth_ff;
   logic [PCT_W-1:0]    rsp_pct_ff;
   logic                rsp_repl_ff, rsp_conn_ff, rsp_chg_ff;

   // ---------------------------------------------------------------- datapath logic
   logic                req_accept;
   logic [SUM_BITS-1:0] sum_in;
   logic [CNT_W-1:0]    taken_in;
   logic [CNT_W-1:0]    burst_len;
   logic                burst_done;

   logic [REM_W:0]      div_trial;
   logic                div_ge;
   logic [REM_W-1:0]    rem_in;
   logic [DQ_W-1:0]     dq_in;

   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [PROD_W-1:0]   prod_in;

   logic [V_W-1:0]      v_full;
   logic                v_replaced;
   logic                smooth_in_window;
   logic [SMOOTH_W-1:0] inst_in;
   logic [FSUM_W-1:0]   filt_sum;
   logic [SEG_W-1:0]    seg_in;
   logic [X_W-1:0]      pct_x;
   logic                conn_now;
   logic                rsp_load;

   assign req_accept = req_valid && !req_stall;
   assign sum_in     = sum_ff + SUM_BITS'(req_adc_sample);
   assign taken_in   = taken_ff + CNT_W'(1);
   // a count of zero means one sample per burst
   assign burst_len  = (sample_count_ff == '0) ? CNT_W'(1) : sample_count_ff;
   assign burst_done = taken_in >= burst_len;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign div_trial = {rem_ff, dq_ff[DQ_W-1]};
   assign div_ge    = div_trial >= {1'b0, div_ff};
   assign rem_in    = div_ge ? REM_W'(div_trial - {1'b0, div_ff}) : REM_W'(div_trial);
   assign dq_in     = {dq_ff[DQ_W-2:0], div_ge};

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // window tests at full precision
   assign v_full     = prod_ff[PROD_W-1:FRAC_W];
   assign v_replaced = (v_full < V_W'({valid_min_ff, {FRAC_W{1'b0}}}))
                    || (v_full > V_W'({valid_max_ff, {FRAC_W{1'b0}}}));
   assign smooth_in_window = (smooth_ff >= {valid_min_ff, {FRAC_W{1'b0}}})
                          && (smooth_ff <= {valid_max_ff, {FRAC_W{1'b0}}});

   always_comb begin
      if (!v_replaced) begin
         inst_in = v_full[SMOOTH_W-1:0];
      end else if (smooth_in_window) begin
         inst_in = smooth_ff;
      end else begin
         inst_in = '0;
      end
   end

   // rounded blend of old value and new reading
   assign filt_sum = FSUM_W'(acc_ff) + FSUM_W'(prod_ff[ACC_W-1:0]) + FSUM_W'(HALF_Q16);

   // curve segment of the smoothed voltage, searched from the top
   always_comb begin
      if (smooth_ff >= SEG_BP_Q8[4]) begin
         seg_in = SEG_W'(4);
      end else if (smooth_ff >= SEG_BP_Q8[3]) begin
         seg_in = SEG_W'(3);
      end else if (smooth_ff >= SEG_BP_Q8[2]) begin
         seg_in = SEG_W'(2);
      end else if (smooth_ff >= SEG_BP_Q8[1]) begin
         seg_in = SEG_W'(1);
      end else begin
         seg_in = SEG_W'(0);
      end
   end

   // numerator of the rounded segment fraction: d*2r + span
   assign pct_x = X_W'(prod_ff[X_W-1:0]) + SEG_HALF[seg_ff];

   assign conn_now = (smooth_ff >= {conn_min_ff, {FRAC_W{1'b0}}})
                  && (smooth_ff <= {conn_max_ff, {FRAC_W{1'b0}}});

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && burst_done) state_in = S_DIV;
         end
         S_DIV: begin
            if (cnt_ff == STEP_W'(1)) state_in = S_MULV;
         end
         S_MULV:  state_in = S_CHECK;
         S_CHECK: state_in = seeded_ff ? S_MULS : S_PSEL;
         S_MULS:  state_in = S_MULI;
         S_MULI:  state_in = S_FILT;
         S_FILT:  state_in = S_PSEL;
         S_PSEL: begin
            if (smooth_ff <= PCT_LO_Q8 || smooth_ff >= PCT_HI_Q8) begin
               state_in = S_DONE;
            end else begin
               state_in = S_PMUL;
            end
         end
         S_PMUL:  state_in = S_PLOAD;
         S_PLOAD: state_in = S_PDIV;
         S_PDIV: begin
            if (cnt_ff == STEP_W'(1)) state_in = S_PSUM;
         end
         S_PSUM:  state_in = S_DONE;
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // controls: input stall, result load, multiplier operands
   always_comb begin
      req_stall = (state_ff != S_IDLE);
      rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         S_MULV: begin
            mul_a = MUL_A_W'(dq_ff[SUM_BITS-1:0]);
            mul_b = mv_per_count_ff;
         end
         S_MULS: begin
            mul_a = MUL_A_W'(smooth_ff);
            mul_b = MUL_B_W'(17'(ONE_Q16) - {1'b0, alpha_ff});
         end
         S_MULI: begin
            mul_a = MUL_A_W'(inst_ff);
            mul_b = MUL_B_W'(alpha_ff);
         end
         S_PMUL: begin
            mul_a = MUL_A_W'(d_ff);
            mul_b = MUL_B_W'(SEG_RISE2[seg_ff]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------- configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff   <= RST_SAMPLE_COUNT;
         mv_per_count_ff   <= RST_MV_PER_COUNT;
         alpha_ff          <= RST_ALPHA;
         valid_min_ff      <= RST_VALID_MIN;
         valid_max_ff      <= RST_VALID_MAX;
         conn_min_ff       <= RST_CONN_MIN;
         conn_max_ff       <= RST_CONN_MAX;
         charge_act_low_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SAMPLE_COUNT:   sample_count_ff   <= csr_data[CNT_W-1:0];
            CSR_MV_PER_COUNT:   mv_per_count_ff   <= csr_data[MVQ_W-1:0];
            CSR_ALPHA:          alpha_ff          <= csr_data[ALPHA_W-1:0];
            CSR_VALID_MIN:      valid_min_ff      <= csr_data[MV_W-1:0];
            CSR_VALID_MAX:      valid_max_ff      <= csr_data[MV_W-1:0];
            CSR_CONN_MIN:       conn_min_ff       <= csr_data[MV_W-1:0];
            CSR_CONN_MAX:       conn_max_ff       <= csr_data[MV_W-1:0];
            CSR_CHARGE_ACT_LOW: charge_act_low_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- burst and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         taken_ff  <= '0;
         seeded_ff <= 1'b0;
         smooth_ff <= '0;
      end else begin
         if (req_accept) begin
            if (burst_done) begin
               // close the burst and start over
               sum_ff   <= '0;
               taken_ff <= '0;
            end else begin
               sum_ff   <= sum_in;
               taken_ff <= taken_in;
            end
         end
         if (state_ff == S_CHECK && !seeded_ff) begin
            // first reading seeds the filter as it is
            smooth_ff <= inst_in;
            seeded_ff <= 1'b1;
         end else if (state_ff == S_FILT) begin
            smooth_ff <= filt_sum[SMOOTH_W+15:16];
         end
      end
   end

   // ---------------------------------------------------------------- work registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && burst_done) begin
               // left-align the sum so the quotient lands in the low bits
               rem_ff <= '0;
               dq_ff  <= DQ_W'(sum_in) << (DQ_W - SUM_BITS);
               div_ff <= REM_W'(burst_len);
               cnt_ff <= STEP_W'(SUM_BITS);
               pin_ff <= req_charge_pin;
            end
         end
         S_DIV, S_PDIV: begin
            rem_ff <= rem_in;
            dq_ff  <= dq_in;
            cnt_ff <= cnt_ff - STEP_W'(1);
         end
         S_MULV: begin
            avg_ff <= dq_ff[AVG_W-1:0];
         end
         S_CHECK: begin
            inst_ff <= inst_in;
            repl_ff <= v_replaced;
         end
         S_MULI: begin
            acc_ff <= prod_ff[ACC_W-1:0];
         end
         S_PSEL: begin
            seg_ff <= seg_in;
            d_ff   <= D_W'(smooth_ff - SEG_BP_Q8[seg_in]);
            pct_ff <= (smooth_ff <= PCT_LO_Q8) ? PCT_EMPTY : PCT_FULL;
         end
         S_PLOAD: begin
            // quotient is below 2^PCT_QB, so the upper bits already sit under the divisor
            rem_ff <= REM_W'(pct_x[X_W-1:PCT_QB]);
            dq_ff  <= DQ_W'(pct_x[PCT_QB-1:0]) << (DQ_W - PCT_QB);
            div_ff <= SEG_DIV[seg_ff];
            cnt_ff <= STEP_W'(PCT_QB);
         end
         S_PSUM: begin
            pct_ff <= SEG_BASE[seg_ff] + PCT_W'(dq_ff[PCT_QB-1:0]);
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_avg_ff    <= avg_ff;
         rsp_inst_ff   <= inst_ff[SMOOTH_W-1:FRAC_W];
         rsp_smooth_ff <= smooth_ff[SMOOTH_W-1:FRAC_W];
         rsp_pct_ff    <= pct_ff;
         rsp_repl_ff   <= repl_ff;
         rsp_conn_ff   <= conn_now;
         rsp_chg_ff    <= conn_now && (charge_act_low_ff ? !pin_ff : pin_ff);
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_raw_average       = rsp_avg_ff;
   assign rsp_instant_mv        = rsp_inst_ff;
   assign rsp_smoothed_mv_out   = rsp_smooth_ff;
   assign rsp_charge_percent    = rsp_pct_ff;
   assign rsp_reading_replaced  = rsp_repl_ff;
   assign rsp_battery_connected = rsp_conn_ff;
   assign rsp_charging          = rsp_chg_ff;

   // ---------------------------------------------------------------- assertions
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_charge_percent <= PCT_FULL))
      else $error("charge percentage above full");

   a_chg_conn: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_charging) |-> rsp_battery_connected)
      else $error("charging flagged without a connected battery");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV || state_ff == S_PDIV) |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

   a_div_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV || state_ff == S_PDIV) |-> (cnt_ff != '0))
      else $error("divider running with no steps left");

endmodule

`default_nettype wire
